### hw/rtl/gdc_pkg.sv
// Shared constants, types and calendar tables for the Gregorian day counter.
`default_nettype none

package gdc_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned TOTAL_W = 22;
    localparam int unsigned ORD_W   = 23;
    localparam int unsigned DOY_W   = 9;
    localparam int unsigned QUAR_W  = YEAR_W - 2;
    localparam int unsigned MULT_W  = 25;
    localparam int unsigned FRAC_W  = 17;
    localparam int unsigned CENT_W  = MULT_W - FRAC_W;
    localparam int unsigned CMP_W   = 17;

    localparam int unsigned DEF_MAX_YEAR = 9999;

    // Reciprocal of 25 scaled by 2**17, rounded up.
    localparam int unsigned RECIP25       = 5243;
    localparam int unsigned DAYS_PER_YEAR = 365;

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    typedef struct packed {
        logic              ok;
        logic [DOY_W-1:0]  doy;
        logic [ORD_W-1:0]  ord;
    } t_date_info;

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] mon,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        unique case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                     len = DAY_W'(30);
            4'd2:                                        len = leap ? DAY_W'(29)
                                                                    : DAY_W'(28);
            default:                                     len = DAY_W'(0);
        endcase
        return len;
    endfunction

    function automatic logic [DOY_W-1:0] days_before(input logic [MON_W-1:0] mon);
        logic [DOY_W-1:0] n;
        unique case (mon)
            4'd1:    n = DOY_W'(0);
            4'd2:    n = DOY_W'(31);
            4'd3:    n = DOY_W'(59);
            4'd4:    n = DOY_W'(90);
            4'd5:    n = DOY_W'(120);
            4'd6:    n = DOY_W'(151);
            4'd7:    n = DOY_W'(181);
            4'd8:    n = DOY_W'(212);
            4'd9:    n = DOY_W'(243);
            4'd10:   n = DOY_W'(273);
            4'd11:   n = DOY_W'(304);
            4'd12:   n = DOY_W'(334);
            default: n = DOY_W'(0);
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/gdc_in_if.sv
// Input channel carrying an operation code and a pair of dates.
`default_nettype none

interface gdc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [gdc_pkg::DAY_W-1:0]  start_day;
    logic [gdc_pkg::MON_W-1:0]  start_month;
    logic [gdc_pkg::YEAR_W-1:0] start_year;
    logic [gdc_pkg::DAY_W-1:0]  end_day;
    logic [gdc_pkg::MON_W-1:0]  end_month;
    logic [gdc_pkg::YEAR_W-1:0] end_year;

    modport source (output valid, op, start_day, start_month, start_year,
                    end_day, end_month, end_year, input ready);
    modport sink   (input valid, op, start_day, start_month, start_year,
                    end_day, end_month, end_year, output ready);
endinterface

`default_nettype wire

### hw/rtl/gdc_out_if.sv
// Output channel carrying the day count and the error flags.
`default_nettype none

interface gdc_out_if;
    logic                        valid;
    logic                        ready;
    logic [gdc_pkg::TOTAL_W-1:0] day_total;
    logic                        bad_date;
    logic                        wrong_order;

    modport source (output valid, day_total, bad_date, wrong_order, input ready);
    modport sink   (input valid, day_total, bad_date, wrong_order, output ready);
endinterface

`default_nettype wire

### hw/rtl/gdc_date_unit.sv
// Three-stage date path: validity check, day of year and day ordinal of one date.
`default_nettype none

module gdc_date_unit #(
    parameter int unsigned MAX_YEAR = gdc_pkg::DEF_MAX_YEAR
) (
    input  logic                       i_clk,
    input  gdc_pkg::t_stage_en         i_en,
    input  logic [gdc_pkg::DAY_W-1:0]  i_day,
    input  logic [gdc_pkg::MON_W-1:0]  i_month,
    input  logic [gdc_pkg::YEAR_W-1:0] i_year,
    output gdc_pkg::t_date_info        o_info
);
    import gdc_pkg::*;

    localparam logic [CMP_W-1:0] MaxYear = CMP_W'(MAX_YEAR);

    // Stage 1: constant multiplications.
    logic [DAY_W-1:0]  r_s1_day;
    logic [MON_W-1:0]  r_s1_mon;
    logic [YEAR_W-1:0] r_s1_year;
    logic [MULT_W-1:0] r_s1_mx;
    logic [MULT_W-1:0] r_s1_mp;
    logic [ORD_W-1:0]  r_s1_y365;

    logic [YEAR_W-1:0] n_s1_prev;
    logic [MULT_W-1:0] n_s1_mx;
    logic [MULT_W-1:0] n_s1_mp;
    logic [ORD_W-1:0]  n_s1_y365;

    always_comb begin
        n_s1_prev = i_year - YEAR_W'(1);
        n_s1_mx   = MULT_W'(i_year[YEAR_W-1:2]) * MULT_W'(RECIP25);
        n_s1_mp   = MULT_W'(n_s1_prev[YEAR_W-1:2]) * MULT_W'(RECIP25);
        n_s1_y365 = ORD_W'(i_year) * ORD_W'(DAYS_PER_YEAR);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_day  <= i_day;
            r_s1_mon  <= i_month;
            r_s1_year <= i_year;
            r_s1_mx   <= n_s1_mx;
            r_s1_mp   <= n_s1_mp;
            r_s1_y365 <= n_s1_y365;
        end
    end

    // Stage 2: leap year, validity, day of year and the year terms.
    logic              r_s2_ok;
    logic [DOY_W-1:0]  r_s2_doy;
    logic [QUAR_W-1:0] r_s2_lp;
    logic [ORD_W-1:0]  r_s2_yd;

    logic              n_s2_div25;
    logic              n_s2_leap;
    logic              n_s2_mon_ok;
    logic              n_s2_ok;
    logic              n_s2_after_feb;
    logic              n_s2_nonzero;
    logic [YEAR_W-1:0] n_s2_prev;
    logic [CENT_W-1:0] n_s2_q100;
    logic [QUAR_W-1:0] n_s2_lp;
    logic [DOY_W-1:0]  n_s2_doy;
    logic [ORD_W-1:0]  n_s2_yd;

    always_comb begin
        // The year over four is divisible by 25 exactly when the fraction bits are small.
        n_s2_div25     = r_s1_mx[FRAC_W-1:0] < FRAC_W'(RECIP25);
        n_s2_leap      = (r_s1_year[1:0] == 2'd0)
                         && (!n_s2_div25 || (r_s1_mx[FRAC_W+1:FRAC_W] == 2'd0));
        n_s2_mon_ok    = (r_s1_mon >= MON_JAN) && (r_s1_mon <= MON_DEC);
        n_s2_ok        = (CMP_W'(r_s1_year) <= MaxYear) && n_s2_mon_ok
                         && (r_s1_day != DAY_W'(0))
                         && (r_s1_day <= month_len(r_s1_mon, n_s2_leap));
        n_s2_after_feb = (r_s1_mon > MON_FEB) && n_s2_leap;
        n_s2_doy       = days_before(r_s1_mon) + DOY_W'(r_s1_day)
                         + DOY_W'(n_s2_after_feb);
        n_s2_nonzero   = r_s1_year != YEAR_W'(0);
        n_s2_prev      = r_s1_year - YEAR_W'(1);
        n_s2_q100      = r_s1_mp[MULT_W-1:FRAC_W];
        n_s2_lp        = n_s2_nonzero
                         ? n_s2_prev[YEAR_W-1:2] - QUAR_W'(n_s2_q100)
                           + QUAR_W'(n_s2_q100[CENT_W-1:2])
                         : QUAR_W'(0);
        n_s2_yd        = r_s1_y365 + ORD_W'(n_s2_nonzero);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_ok  <= n_s2_ok;
            r_s2_doy <= n_s2_doy;
            r_s2_lp  <= n_s2_lp;
            r_s2_yd  <= n_s2_yd;
        end
    end

    // Stage 3: day ordinal.
    logic             r_s3_ok;
    logic [DOY_W-1:0] r_s3_doy;
    logic [ORD_W-1:0] r_s3_ord;
    logic [ORD_W-1:0] n_s3_ord;

    assign n_s3_ord = r_s2_yd + ORD_W'(r_s2_doy) + ORD_W'(r_s2_lp);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_ok  <= r_s2_ok;
            r_s3_doy <= r_s2_doy;
            r_s3_ord <= n_s3_ord;
        end
    end

    assign o_info = '{ok: r_s3_ok, doy: r_s3_doy, ord: r_s3_ord};

endmodule

`default_nettype wire

### hw/rtl/gregorian_day_count.sv
// Top level of the Gregorian day counter: stage control, both date paths and the result stage.
// Throughput is one date pair per cycle through four register stages, three in each date
// path and one result register; a stalled output holds every stage behind it in place.
// Reset is synchronous and active low; it clears the stage valid bits only.
`default_nettype none

module gregorian_day_count #(
    parameter int unsigned MAX_YEAR = gdc_pkg::DEF_MAX_YEAR
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gdc_in_if.sink           i_in,
    gdc_out_if.source        o_out
);
    import gdc_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4;
    logic r_op1, r_op2, r_op3;
    logic en1, en2, en3, en4;
    t_stage_en  stage_en;
    t_date_info start_info;
    t_date_info end_info;

    assign en4 = !r_v4 || o_out.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign stage_en = '{s1: en1, s2: en2, s3: en3};
    assign i_in.ready = en1;

    gdc_date_unit #(.MAX_YEAR(MAX_YEAR)) u_start (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_day   (i_in.start_day),
        .i_month (i_in.start_month),
        .i_year  (i_in.start_year),
        .o_info  (start_info)
    );

    gdc_date_unit #(.MAX_YEAR(MAX_YEAR)) u_end (
        .i_clk   (i_clk),
        .i_en    (stage_en),
        .i_day   (i_in.end_day),
        .i_month (i_in.end_month),
        .i_year  (i_in.end_year),
        .o_info  (end_info)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_in.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_op1 <= i_in.op;
        end
        if (en2) begin
            r_op2 <= r_op1;
        end
        if (en3) begin
            r_op3 <= r_op2;
        end
    end

    // Result stage.
    logic [TOTAL_W-1:0] r_total;
    logic               r_bad;
    logic               r_order;
    logic [TOTAL_W-1:0] n_total;
    logic               n_bad;
    logic               n_order;
    logic [ORD_W-1:0]   span;

    always_comb begin
        span    = end_info.ord - start_info.ord + ORD_W'(1);
        n_bad   = r_op3 ? !start_info.ok : !(start_info.ok && end_info.ok);
        n_order = !r_op3 && !n_bad && (end_info.ord < start_info.ord);
        if (n_bad || n_order) begin
            n_total = TOTAL_W'(0);
        end else if (r_op3) begin
            n_total = TOTAL_W'(start_info.doy);
        end else begin
            n_total = span[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_total <= n_total;
            r_bad   <= n_bad;
            r_order <= n_order;
        end
    end

    assign o_out.valid       = r_v4;
    assign o_out.day_total   = r_total;
    assign o_out.bad_date    = r_bad;
    assign o_out.wrong_order = r_order;

endmodule

`default_nettype wire

### hw/rtl/gdc_checker.sv
// Port-level checks of the Gregorian day counter and their binding to the top level.
`default_nettype none

module gdc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [gdc_pkg::TOTAL_W-1:0] i_day_total,
    input logic                        i_bad_date,
    input logic                        i_wrong_order
);
    import gdc_pkg::*;

    // A result that waits for its transfer keeps its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_day_total)
            && $stable(i_bad_date) && $stable(i_wrong_order))
        else $error("Stalled result changed before its transfer.");

    // The order check only runs on valid dates.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_bad_date && i_wrong_order))
        else $error("Both error flags are set on one result.");

    // Any error forces a zero count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_bad_date || i_wrong_order) |-> i_day_total == TOTAL_W'(0))
        else $error("Nonzero count on a flagged result.");

    // Reset empties the pipeline.
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

endmodule

bind gregorian_day_count gdc_checker u_gdc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_day_total   (o_out.day_total),
    .i_bad_date    (o_out.bad_date),
    .i_wrong_order (o_out.wrong_order)
);

`default_nettype wire
